// ===== rtl/lesf_pkg.sv =====
// ----------------------------------------------------------------------------
// lesf_pkg
// Shared widths, the reset constant and the per-cell control bundle of the
// largest empty square finder.
// ----------------------------------------------------------------------------
package lesf_pkg;

  // fixed field widths of the ports
  localparam int CHAR_W = 8;
  localparam int SIZE_W = 11;
  localparam int POS_W  = 10;

  // empty character after reset ('.')
  localparam logic [CHAR_W-1:0] EMPTY_RESET = 8'd46;

  // control bits of one cell, passed from the position stage to the update stage
  typedef struct packed {
    logic in_grid;   // cell lies inside the height and width bounds
    logic empty;     // cell matches the empty character
    logic up_ok;     // entry above was written by the previous row
    logic row_clr;   // row ends after this cell
    logic last;      // grid ends after this cell
  } lesf_ctl_t;

endpackage

// ===== rtl/largest_empty_square_finder_unit.sv =====
// ----------------------------------------------------------------------------
// largest_empty_square_finder_unit
// Result path: grid_end passes the stage register, then the result register.
// Throughput: one cell per cycle, set by the one-read one-write line store, while no result stall holds the input.
// Reset (synchronous, rst_n low): empty character 46, grid state cleared; no sweep.
// ----------------------------------------------------------------------------
module largest_empty_square_finder_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [lesf_pkg::CHAR_W-1:0] in_cell_char,
  input  logic                        in_row_end,
  input  logic                        in_grid_end,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [lesf_pkg::SIZE_W-1:0] out_square_size,
  output logic [lesf_pkg::POS_W-1:0]  out_top_row,
  output logic [lesf_pkg::POS_W-1:0]  out_left_column,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [lesf_pkg::CHAR_W-1:0] cfg_empty_char
);

  import lesf_pkg::*;

  localparam int AW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CW    = $clog2(MAX_WIDTH + 1);
  localparam int RAW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int RW    = $clog2(MAX_HEIGHT + 1);
  localparam int MINWH = (MAX_WIDTH < MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int VW    = $clog2(MINWH + 1);

  logic [CHAR_W-1:0] empty_char_r;
  logic [CW-1:0]     col_r,  col_nxt;
  logic [RW-1:0]     row_r,  row_nxt;
  logic [CW-1:0]     alen_r, alen_nxt;
  logic [CW-1:0]     col_adv;
  logic              in_fire;
  logic              row_ok;
  logic              col_ok;
  lesf_ctl_t         ctl;
  logic              hold;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [VW-1:0]     wr_data;
  logic [VW-1:0]     up_data;

  // configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      empty_char_r <= EMPTY_RESET;
    end else if (cfg_valid) begin
      empty_char_r <= cfg_empty_char;
    end
  end

  // input transaction
  assign in_stall = hold;
  assign in_fire  = in_valid && !in_stall;

  // position of the incoming cell
  always_comb begin
    row_ok      = row_r < RW'(MAX_HEIGHT);
    col_ok      = col_r < CW'(MAX_WIDTH);
    ctl.in_grid = row_ok && col_ok;
    ctl.empty   = (in_cell_char == empty_char_r);
    ctl.up_ok   = col_r < alen_r;
    ctl.row_clr = in_row_end || in_grid_end;
    ctl.last    = in_grid_end;
    col_adv     = ctl.in_grid ? col_r + CW'(1) : col_r;
  end

  // row, column and previous-row length counters
  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    alen_nxt = alen_r;
    if (in_fire) begin
      if (in_grid_end) begin
        col_nxt  = '0;
        row_nxt  = '0;
        alen_nxt = '0;
      end else if (in_row_end) begin
        if (row_ok) begin
          alen_nxt = col_adv;
          row_nxt  = row_r + RW'(1);
        end
        col_nxt = '0;
      end else begin
        col_nxt = col_adv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      alen_r <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      alen_r <= alen_nxt;
    end
  end

  // previous-row line store
  lesf_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW),
    .VW    (VW)
  ) u_line_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_fire && ctl.in_grid),
    .rd_addr (col_r[AW-1:0]),
    .rd_data (up_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // recurrence, best tracking and result register
  lesf_cell #(
    .VW  (VW),
    .AW  (AW),
    .RAW (RAW)
  ) u_cell (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (in_fire),
    .ctl_in          (ctl),
    .col_in          (col_r[AW-1:0]),
    .row_in          (row_r[RAW-1:0]),
    .up_data         (up_data),
    .hold            (hold),
    .wr_en           (wr_en),
    .wr_addr         (wr_addr),
    .wr_data         (wr_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_square_size (out_square_size),
    .out_top_row     (out_top_row),
    .out_left_column (out_left_column)
  );

`ifndef SYNTHESIS
  // input is only held back by a waiting result
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no pending result");

  // a new result must be preceded by an accepted grid_end transaction
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall && in_grid_end, 2))
    else $error("result without a matching grid_end transaction");

  // column counter and previous-row length do not exceed the line store depth
  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (col_r <= CW'(MAX_WIDTH)) && (alen_r <= CW'(MAX_WIDTH)))
    else $error("column count beyond line store depth");
`endif

endmodule

// ===== rtl/lesf_line_mem.sv =====
// ----------------------------------------------------------------------------
// lesf_line_mem
// Line store of the previous row's run sizes: one write and one read port,
// registered read data, with forwarding of a same-cycle write to the same
// entry.
// ----------------------------------------------------------------------------
module lesf_line_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int VW    = 11
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [VW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [VW-1:0] wr_data
);

  logic [VW-1:0] mem [DEPTH];
  logic [VW-1:0] rd_q_r;
  logic [VW-1:0] fwd_data_r;
  logic          fwd_r;

  // storage: write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r     <= mem[rd_addr];
      fwd_data_r <= wr_data;
    end
  end

  // a write landing on the entry being read in the same cycle is forwarded
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (rd_en) begin
      fwd_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = fwd_r ? fwd_data_r : rd_q_r;

endmodule

// ===== rtl/lesf_cell.sv =====
// ----------------------------------------------------------------------------
// lesf_cell
// Update stage: evaluates the maximal-square recurrence for one cell, keeps
// the left and diagonal values and the best square, and holds the result
// register of the output channel.
// ----------------------------------------------------------------------------
module lesf_cell #(
  parameter int VW  = 11,
  parameter int AW  = 10,
  parameter int RAW = 10
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      load,
  input  lesf_pkg::lesf_ctl_t       ctl_in,
  input  logic [AW-1:0]             col_in,
  input  logic [RAW-1:0]            row_in,
  input  logic [VW-1:0]             up_data,
  output logic                      hold,
  output logic                      wr_en,
  output logic [AW-1:0]             wr_addr,
  output logic [VW-1:0]             wr_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [lesf_pkg::SIZE_W-1:0] out_square_size,
  output logic [lesf_pkg::POS_W-1:0]  out_top_row,
  output logic [lesf_pkg::POS_W-1:0]  out_left_column
);

  import lesf_pkg::*;

  localparam int XW = VW + AW + RAW + SIZE_W + POS_W;

  logic            s1_valid_r;
  lesf_ctl_t       s1_ctl_r;
  logic [AW-1:0]   s1_col_r;
  logic [RAW-1:0]  s1_row_r;
  logic [VW-1:0]   left_r;
  logic [VW-1:0]   diag_r;
  logic [VW-1:0]   best_r;
  logic [RAW-1:0]  brow_r;
  logic [AW-1:0]   bcol_r;
  logic            ov_r;
  logic [VW-1:0]   osize_r;
  logic [RAW-1:0]  orow_r;
  logic [AW-1:0]   ocol_r;

  logic            fire;
  logic [VW-1:0]   up;
  logic [VW-1:0]   min_ul;
  logic [VW-1:0]   min_all;
  logic [VW-1:0]   v;
  logic            better;
  logic [VW-1:0]   bsize_fin;
  logic [RAW-1:0]  brow_fin;
  logic [AW-1:0]   bcol_fin;
  logic [XW-1:0]   size_ext;
  logic [XW-1:0]   top_full;
  logic [XW-1:0]   left_full;

  // stage stalls only when a finished grid meets a full, stalled result register
  assign hold = s1_valid_r && s1_ctl_r.last && ov_r && out_stall;
  assign fire = s1_valid_r && !hold;

  // recurrence: one plus the minimum of above, left and diagonal for an empty cell, else zero
  always_comb begin
    up      = s1_ctl_r.up_ok ? up_data : '0;
    min_ul  = (up < left_r) ? up : left_r;
    min_all = (min_ul < diag_r) ? min_ul : diag_r;
    v       = s1_ctl_r.empty ? min_all + VW'(1) : '0;
  end

  // best square, replaced on strict improvement only
  always_comb begin
    better    = s1_ctl_r.in_grid && (v > best_r);
    bsize_fin = better ? v : best_r;
    brow_fin  = better ? s1_row_r : brow_r;
    bcol_fin  = better ? s1_col_r : bcol_r;
  end

  // write back into the line store
  assign wr_en   = fire && s1_ctl_r.in_grid;
  assign wr_addr = s1_col_r;
  assign wr_data = v;

  // stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_ctl_r   <= '0;
    end else if (!hold) begin
      s1_valid_r <= load;
      s1_ctl_r   <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_col_r <= col_in;
      s1_row_r <= row_in;
    end
  end

  // left, diagonal and best state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
      diag_r <= '0;
      best_r <= '0;
      brow_r <= '0;
      bcol_r <= '0;
    end else if (fire) begin
      if (s1_ctl_r.row_clr) begin
        left_r <= '0;
        diag_r <= '0;
      end else if (s1_ctl_r.in_grid) begin
        left_r <= v;
        diag_r <= up;
      end
      if (s1_ctl_r.last) begin
        best_r <= '0;
        brow_r <= '0;
        bcol_r <= '0;
      end else begin
        best_r <= bsize_fin;
        brow_r <= brow_fin;
        bcol_r <= bcol_fin;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (fire && s1_ctl_r.last) begin
      ov_r <= 1'b1;
    end else if (!out_stall) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && s1_ctl_r.last) begin
      osize_r <= bsize_fin;
      orow_r  <= brow_fin;
      ocol_r  <= bcol_fin;
    end
  end

  // top-left corner from the bottom-right corner and the side
  always_comb begin
    size_ext  = XW'(osize_r);
    top_full  = '0;
    left_full = '0;
    if (osize_r != '0) begin
      top_full  = XW'(orow_r) + XW'(1) - size_ext;
      left_full = XW'(ocol_r) + XW'(1) - size_ext;
    end
  end

  assign out_valid       = ov_r;
  assign out_square_size = size_ext[SIZE_W-1:0];
  assign out_top_row     = top_full[POS_W-1:0];
  assign out_left_column = left_full[POS_W-1:0];

endmodule
